// File: rtl/cross_blur_3x3_stream_core_defines.svh
// Assertion macros for the cross blur core.
// Taken in by files that carry concurrent checks; depends on nothing else.
`ifndef CROSS_BLUR_3X3_STREAM_CORE_DEFINES_SVH
`define CROSS_BLUR_3X3_STREAM_CORE_DEFINES_SVH

// Same-cycle implication, sampled on aclk, idle in reset
`define CB3_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cross blur check failed");

// Next-cycle implication, sampled on aclk, idle in reset
`define CB3_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cross blur check failed");

`endif

// File: rtl/cb3_pkg.sv
// Shared constants and types for the cross blur core.
// No dependencies; imported by the top level.
package cb3_pkg;

    // Field and register widths
    localparam int PIXEL_BITS      = 8;
    localparam int SRC_WIDTH_BITS  = 12;
    localparam int SRC_HEIGHT_BITS = 16;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_ADDR_BITS   = 1;

    // Default line store depth
    localparam int DEF_MAX_WIDTH = 2048;

    // Register reset values
    localparam logic [SRC_WIDTH_BITS-1:0]  SRC_WIDTH_RESET  = 12'd640;
    localparam logic [SRC_HEIGHT_BITS-1:0] SRC_HEIGHT_RESET = 16'd480;

    // Smallest frame dimension the window supports
    localparam int MIN_DIM = 3;

    // Stencil sum: 4*c + l + r + u + d + 4 fits in 11 bits
    localparam int                 SUM_BITS   = 11;
    localparam logic [SUM_BITS-1:0] ROUND_BIAS = 11'd4;
    localparam int                 SUM_SHIFT  = 3;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_SRC_WIDTH  = 1'b0,
        REG_SRC_HEIGHT = 1'b1
    } cfg_reg_t;

endpackage

// File: rtl/cb3_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module cb3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/cross_blur_3x3_stream_core.sv
// Top level of the five-point cross blur over an 8-bit grayscale stream.
// Depends on cb3_pkg, cb3_ram and cross_blur_3x3_stream_core_defines.svh.
//
// Takes one source pixel per request in raster order and returns the blurred
// interior, (src_width-2) by (src_height-2) pixels, each value being
// (4*centre + left + right + up + down + 4) / 8. m_tlast marks the last pixel
// of an output row and m_tuser the last pixel of the frame. Throughput is one
// pixel per clock while m_tready stays high. The line store is read at the
// edge that accepts a pixel; the stencil add, the line store write-back and
// the output register load follow at the edge on which stage B advances,
// which a stalled output (m_tready low with m_tvalid high) can hold back.
// Both previous source rows live in one RAM of MAX_WIDTH entries, 16 bits
// wide, read and rewritten at the same column once per pixel. The RAM has no
// clearing pass and is usable straight after reset. src_width is clamped to
// 3..MAX_WIDTH and src_height to at least 3; write the registers only while
// the core is idle, between frames.
`include "cross_blur_3x3_stream_core_defines.svh"

module cross_blur_3x3_stream_core #(
    parameter int MAX_WIDTH = cb3_pkg::DEF_MAX_WIDTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port
    input  logic                               cfg_we,
    input  logic [cb3_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [cb3_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    // Source pixels
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [cb3_pkg::PIXEL_BITS-1:0]     s_tdata,   // [7:0] pixel
    // Blurred pixels
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cb3_pkg::PIXEL_BITS-1:0]     m_tdata,   // [7:0] blurred
    output logic                               m_tlast,   // row_end
    output logic                               m_tuser    // [0] frame_end
);

    import cb3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int MW_BITS = $clog2(MAX_WIDTH + 1);
    localparam int EW = (SRC_WIDTH_BITS > MW_BITS) ? SRC_WIDTH_BITS : MW_BITS;
    localparam int RAM_BITS = 2 * PIXEL_BITS;

    // Configuration registers
    logic [SRC_WIDTH_BITS-1:0]  src_width_reg;
    logic [SRC_HEIGHT_BITS-1:0] src_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= SRC_WIDTH_RESET;
            src_height_reg <= SRC_HEIGHT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_SRC_WIDTH:  src_width_reg  <= cfg_wdata[SRC_WIDTH_BITS-1:0];
                REG_SRC_HEIGHT: src_height_reg <= cfg_wdata[SRC_HEIGHT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Clamped frame dimensions
    logic [EW-1:0]              w_ext;
    logic [EW-1:0]              w_eff;
    logic [SRC_HEIGHT_BITS-1:0] h_eff;

    always_comb begin
        w_ext = EW'(src_width_reg);
        if (w_ext < EW'(MIN_DIM)) begin
            w_eff = EW'(MIN_DIM);
        end else if (w_ext > EW'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        if (src_height_reg < SRC_HEIGHT_BITS'(MIN_DIM)) begin
            h_eff = SRC_HEIGHT_BITS'(MIN_DIM);
        end else begin
            h_eff = src_height_reg;
        end
    end

    // Pipeline handshake
    logic s_acc;
    logic b_adv;
    logic out_free;
    logic m_valid_reg;

    logic                  s1_valid_reg;
    logic [PIXEL_BITS-1:0] s1_pixel_reg;
    logic [CW-1:0]         s1_col_reg;
    logic                  s1_emit_reg;
    logic                  s1_row_end_reg;
    logic                  s1_frame_end_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign b_adv    = s1_valid_reg && (!s1_emit_reg || out_free);
    assign s_tready = !s1_valid_reg || b_adv;
    assign s_acc    = s_tvalid && s_tready;

    // Stage A: position counters and line store read
    logic [CW-1:0]              col_reg;
    logic [SRC_HEIGHT_BITS-1:0] row_reg;
    logic [CW-1:0]              col_next;
    logic [SRC_HEIGHT_BITS-1:0] row_next;
    logic [EW-1:0]              col_inc;
    logic [SRC_HEIGHT_BITS:0]   row_inc;
    logic                       last_col;
    logic                       last_row;
    logic                       emit_a;

    always_comb begin
        col_inc  = EW'(col_reg) + EW'(1);
        row_inc  = {1'b0, row_reg} + (SRC_HEIGHT_BITS+1)'(1);
        last_col = (col_inc >= w_eff);
        last_row = (row_inc >= {1'b0, h_eff});
        emit_a   = (row_reg >= SRC_HEIGHT_BITS'(2)) && (col_reg >= CW'(2));
        col_next = col_reg;
        row_next = row_reg;
        if (s_acc) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_inc[SRC_HEIGHT_BITS-1:0];
            end else begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage A to B register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_acc) begin
            s1_valid_reg <= 1'b1;
        end else if (b_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_pixel_reg     <= s_tdata;
            s1_col_reg       <= col_reg;
            s1_emit_reg      <= emit_a;
            s1_row_end_reg   <= last_col;
            s1_frame_end_reg <= last_col && last_row;
        end
    end

    // Line store: upper byte is the row above, lower byte the middle row.
    // A column is read again only a full row (three pixels at least) after
    // its write-back, so reads and writes never meet on one entry.
    logic [RAM_BITS-1:0]   ram_rd_data;
    logic [PIXEL_BITS-1:0] up_px;
    logic [PIXEL_BITS-1:0] mid_px;

    cb3_ram #(
        .WIDTH (RAM_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (b_adv),
        .wr_addr (s1_col_reg),
        .wr_data ({mid_px, s1_pixel_reg}),
        .rd_en   (s_acc),
        .rd_addr (col_reg),
        .rd_data (ram_rd_data)
    );

    assign up_px  = ram_rd_data[RAM_BITS-1:PIXEL_BITS];
    assign mid_px = ram_rd_data[PIXEL_BITS-1:0];

    // Stage B: window shift and stencil sum
    logic [PIXEL_BITS-1:0] win_reg [2];
    logic [PIXEL_BITS-1:0] top_reg;
    logic [PIXEL_BITS-1:0] bot_reg;
    logic [SUM_BITS-1:0]   sum;

    // left = win[0], centre = win[1], right = mid, up = top, down = bottom
    assign sum = (SUM_BITS'(win_reg[1]) << 2) + SUM_BITS'(win_reg[0])
               + SUM_BITS'(mid_px) + SUM_BITS'(top_reg)
               + SUM_BITS'(bot_reg) + ROUND_BIAS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg[0] <= '0;
            win_reg[1] <= '0;
            top_reg    <= '0;
            bot_reg    <= '0;
        end else if (b_adv) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= mid_px;
            top_reg    <= up_px;
            bot_reg    <= s1_pixel_reg;
        end
    end

    // Output register
    logic [PIXEL_BITS-1:0] m_data_reg;
    logic                  m_last_reg;
    logic                  m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_adv && s1_emit_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_adv && s1_emit_reg) begin
            m_data_reg <= sum[SUM_SHIFT +: PIXEL_BITS];
            m_last_reg <= s1_row_end_reg;
            m_user_reg <= s1_frame_end_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    // Checks
    `CB3_ASSERT_NOW(a_frame_end_ends_row, m_tvalid && m_tuser, m_tlast)
    `CB3_ASSERT_NOW(a_accept_frees_stage, s_acc && s1_valid_reg, b_adv)
    `CB3_ASSERT_NEXT(a_stall_holds_stage, s1_valid_reg && !b_adv,
                     s1_valid_reg && $stable(s1_col_reg) && $stable(s1_pixel_reg))

endmodule
